FILE: hdl/mlfr_pkg.sv
// ----------------------------------------------------------------------------
// mlfr_pkg
// Shared types and constants for the marker and length framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfr_pkg;

  localparam int TIMER_BITS   = 16;
  localparam int TIMEOUT_W    = 16;
  localparam int CMP_W        = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(200);

  localparam logic [7:0] START_BYTE1 = 8'h55;
  localparam logic [7:0] START_BYTE2 = 8'hAA;
  localparam logic [7:0] END_BYTE1   = 8'hDE;
  localparam logic [7:0] END_BYTE2   = 8'hF0;
  localparam logic [7:0] MAX_PAYLOAD = 8'd250;
  localparam logic [7:0] LEN_OFFSET  = 8'd2;
  localparam logic [7:0] HDR_BYTES   = 8'd4;
  localparam logic [8:0] TAIL_BYTES  = 9'd5;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_ARM  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SEARCH   = 3'd1,
    ST_DONE     = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_OVERLEN  = 3'd4
  } status_t;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_START1  = 9'b000000010,
    PH_START2  = 9'b000000100,
    PH_BODY    = 9'b000001000,
    PH_END1    = 9'b000010000,
    PH_END2    = 9'b000100000,
    PH_DONE    = 9'b001000000,
    PH_TIMEOUT = 9'b010000000,
    PH_OVERLEN = 9'b100000000
  } phase_t;

endpackage

`default_nettype wire

FILE: hdl/marker_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// marker_length_frame_receiver
// Hunts for a 0x55 0xAA marked, length-sized answer frame in a byte stream,
// reports each body byte and offset; ends on end marker, timeout or overlength.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: rx_byte; tuser: op
//  m_*      out  m_tvalid/m_tready    tdata: status, byte_index, byte_value
//                                     tuser: byte_valid
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: timeout_ticks
//
//  One beat per cycle sustained while the output is not stalled; an accepted
//  beat is loaded into the input register and from there into the result
//  register, which drives m_*.
//  Reset: search idle, timeout_ticks = 200, both registers empty.
//  A stalled output holds the result; the input register still takes one beat.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_length_frame_receiver
  import mlfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // [2:0] status, [10:3] byte_index,
                                      // [18:11] byte_value, [23:19] zero
  output      logic [0:0]  m_tuser,   // [0] byte_valid
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data   // [15:0] timeout_ticks
);

  logic [TIMEOUT_W-1:0]  timeout_ticks;
  logic                  in_valid;
  logic [1:0]            in_op;
  logic [7:0]            in_byte;
  logic                  advance;

  phase_t                rx_phase, rx_phase_next;
  logic [7:0]            body_count, body_count_next;
  logic [7:0]            payload_length, payload_length_next;
  logic [TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;

  status_t               status_next;
  logic                  byte_valid_next;
  logic [7:0]            byte_index_next;
  logic [7:0]            byte_value_next;

  logic                  searching;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign searching = (rx_phase == PH_START1) || (rx_phase == PH_START2) ||
                     (rx_phase == PH_BODY)   || (rx_phase == PH_END1)   ||
                     (rx_phase == PH_END2);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  always_comb begin
    rx_phase_next       = rx_phase;
    body_count_next     = body_count;
    payload_length_next = payload_length;
    elapsed_ticks_next  = elapsed_ticks;
    byte_valid_next     = 1'b0;
    byte_index_next     = '0;
    byte_value_next     = '0;
    case (in_op)
      OP_ARM: begin
        rx_phase_next       = PH_START1;
        body_count_next     = '0;
        payload_length_next = '0;
        elapsed_ticks_next  = '0;
      end
      OP_TICK: begin
        if (searching) begin
          if (elapsed_ticks != '1) begin
            elapsed_ticks_next = elapsed_ticks + 1'b1;
          end
          if (CMP_W'(elapsed_ticks_next) > CMP_W'(timeout_ticks)) begin
            rx_phase_next = PH_TIMEOUT;
          end
        end
      end
      OP_BYTE: begin
        case (rx_phase)
          PH_START1: begin
            body_count_next = '0;
            if (in_byte == START_BYTE1) begin
              rx_phase_next = PH_START2;
            end
          end
          PH_START2: begin
            rx_phase_next = (in_byte == START_BYTE2) ? PH_BODY : PH_START1;
          end
          PH_BODY: begin
            byte_valid_next = 1'b1;
            byte_index_next = body_count;
            byte_value_next = in_byte;
            if ((body_count == LEN_OFFSET) && (in_byte > MAX_PAYLOAD)) begin
              payload_length_next = in_byte;
              rx_phase_next       = PH_OVERLEN;
            end else if (body_count == LEN_OFFSET) begin
              payload_length_next = in_byte;
              body_count_next     = body_count + 1'b1;
            end else if ((body_count >= HDR_BYTES) &&
                         ({1'b0, body_count} == ({1'b0, payload_length} + TAIL_BYTES))) begin
              rx_phase_next = PH_END1;
            end else begin
              body_count_next = body_count + 1'b1;
            end
          end
          PH_END1: begin
            rx_phase_next = (in_byte == END_BYTE1) ? PH_END2 : PH_START1;
          end
          PH_END2: begin
            rx_phase_next = (in_byte == END_BYTE2) ? PH_DONE : PH_START1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    case (rx_phase_next)
      PH_START1, PH_START2, PH_BODY, PH_END1, PH_END2: status_next = ST_SEARCH;
      PH_DONE:    status_next = ST_DONE;
      PH_TIMEOUT: status_next = ST_TIMEOUT;
      PH_OVERLEN: status_next = ST_OVERLEN;
      default:    status_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase       <= PH_IDLE;
      body_count     <= '0;
      payload_length <= '0;
      elapsed_ticks  <= '0;
    end else if (advance) begin
      rx_phase       <= rx_phase_next;
      body_count     <= body_count_next;
      payload_length <= payload_length_next;
      elapsed_ticks  <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, byte_value_next, byte_index_next, status_next};
      m_tuser <= byte_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mlfr_chk.sv
// ----------------------------------------------------------------------------
// mlfr_chk
// Port-level checks for the marker and length framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfr_chk
  import mlfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  a_unstored_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[18:3] == 16'd0)
    else $error("unstored beat carries nonzero index or value");

  a_stored_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[2:0] == ST_SEARCH || m_tdata[2:0] == ST_OVERLEN)
    else $error("stored byte with status other than searching or overlength");

  a_overlen_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ST_OVERLEN && m_tuser[0] |->
      m_tdata[10:3] == 8'd2 && m_tdata[18:11] > MAX_PAYLOAD)
    else $error("overlength flagged on a byte other than a long length byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind marker_length_frame_receiver mlfr_chk u_mlfr_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
